@@ sv/ted_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_pkg: shared types, codes and byte tables for the text encoding detector
// Holds the UTF-8 class and next-state functions and the GBK / Big5 pair tests.
// ----------------------------------------------------------------------------
package ted_pkg;

  typedef logic [2:0] code_t;
  typedef logic [3:0] u8_state_t;
  typedef logic [3:0] byte_kind_t;
  typedef logic [1:0] hit_t;

  // result codes
  localparam code_t CODE_UNKNOWN = 3'd0;
  localparam code_t CODE_ASCII   = 3'd1;
  localparam code_t CODE_UTF8    = 3'd2;
  localparam code_t CODE_GBK     = 3'd3;
  localparam code_t CODE_BIG5    = 3'd4;

  // UTF-8 automaton states
  localparam u8_state_t U8_START = 4'd0;
  localparam u8_state_t U8_A     = 4'd1;
  localparam u8_state_t U8_B     = 4'd2;
  localparam u8_state_t U8_C     = 4'd3;
  localparam u8_state_t U8_D     = 4'd4;
  localparam u8_state_t U8_E     = 4'd5;
  localparam u8_state_t U8_F     = 4'd6;
  localparam u8_state_t U8_G     = 4'd7;
  localparam u8_state_t U8_ERR   = 4'd8;

  // byte classes
  localparam byte_kind_t BC_ASCII   = 4'd0;
  localparam byte_kind_t BC_CONT_80 = 4'd1;
  localparam byte_kind_t BC_CONT_90 = 4'd2;
  localparam byte_kind_t BC_CONT_A0 = 4'd3;
  localparam byte_kind_t BC_BAD     = 4'd4;
  localparam byte_kind_t BC_LEAD2   = 4'd5;
  localparam byte_kind_t BC_E0      = 4'd6;
  localparam byte_kind_t BC_LEAD3   = 4'd7;
  localparam byte_kind_t BC_ED      = 4'd8;
  localparam byte_kind_t BC_F0      = 4'd9;
  localparam byte_kind_t BC_LEAD4   = 4'd10;
  localparam byte_kind_t BC_F4      = 4'd11;

  // first pair hit
  localparam hit_t HIT_NONE = 2'd0;
  localparam hit_t HIT_GBK  = 2'd1;
  localparam hit_t HIT_BIG5 = 2'd2;

  // one input beat as it leaves the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  function automatic byte_kind_t byte_kind(input logic [7:0] b);
    byte_kind_t c;
    begin
      c = BC_BAD;
      if (b inside {[8'h00:8'h7F]}) c = BC_ASCII;
      else if (b inside {[8'h80:8'h8F]}) c = BC_CONT_80;
      else if (b inside {[8'h90:8'h9F]}) c = BC_CONT_90;
      else if (b inside {[8'hA0:8'hBF]}) c = BC_CONT_A0;
      else if (b inside {[8'hC2:8'hDF]}) c = BC_LEAD2;
      else if (b == 8'hE0) c = BC_E0;
      else if (b == 8'hED) c = BC_ED;
      else if (b inside {[8'hE1:8'hEF]}) c = BC_LEAD3;
      else if (b == 8'hF0) c = BC_F0;
      else if (b inside {[8'hF1:8'hF3]}) c = BC_LEAD4;
      else if (b == 8'hF4) c = BC_F4;
      return c;
    end
  endfunction

  function automatic u8_state_t u8_next(input byte_kind_t c, input u8_state_t st);
    u8_state_t n;
    begin
      n = U8_ERR;
      case (c)
        BC_ASCII:   if (st == U8_START) n = U8_START;
        BC_CONT_80: begin
          case (st)
            U8_A:        n = U8_START;
            U8_B, U8_D:  n = U8_A;
            U8_E, U8_G:  n = U8_B;
            default:     n = U8_ERR;
          endcase
        end
        BC_CONT_90: begin
          case (st)
            U8_A:        n = U8_START;
            U8_B, U8_D:  n = U8_A;
            U8_E, U8_F:  n = U8_B;
            default:     n = U8_ERR;
          endcase
        end
        BC_CONT_A0: begin
          case (st)
            U8_A:        n = U8_START;
            U8_B, U8_C:  n = U8_A;
            U8_E, U8_F:  n = U8_B;
            default:     n = U8_ERR;
          endcase
        end
        BC_LEAD2:   if (st == U8_START) n = U8_A;
        BC_E0:      if (st == U8_START) n = U8_C;
        BC_LEAD3:   if (st == U8_START) n = U8_B;
        BC_ED:      if (st == U8_START) n = U8_D;
        BC_F0:      if (st == U8_START) n = U8_F;
        BC_LEAD4:   if (st == U8_START) n = U8_E;
        BC_F4:      if (st == U8_START) n = U8_G;
        default:    n = U8_ERR;
      endcase
      return n;
    end
  endfunction

  function automatic logic pair_gbk(input logic [7:0] hi, input logic [7:0] lo);
    return (hi inside {[8'h81:8'hFE]}) &&
           ((lo inside {[8'h40:8'h7E]}) || (lo inside {[8'h80:8'hFE]}));
  endfunction

  function automatic logic pair_big5(input logic [7:0] hi, input logic [7:0] lo);
    return (hi inside {[8'hA1:8'hFE]}) &&
           ((lo inside {[8'h40:8'h7E]}) || (lo inside {[8'hA1:8'hFE]}));
  endfunction

endpackage

@@ sv/ted_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ted_core: per-line detection state
// Runs the UTF-8 automaton, the pair tests and the seen flags for one beat and
// forms the line's code from the updated state.
// ----------------------------------------------------------------------------
module ted_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  ted_pkg::beat_t beat,
  output ted_pkg::code_t code
);
  import ted_pkg::*;

  u8_state_t  dfa_state, dfa_state_next;
  logic [7:0] prior_byte;
  logic       prior_was_high;
  hit_t       first_pair_hit, first_pair_hit_next;
  logic       saw_ascii, saw_ascii_next;
  logic       saw_high, saw_high_next;
  logic       is_high;

  assign is_high = beat.data[7];

  always_comb begin
    dfa_state_next = u8_next(byte_kind(beat.data), dfa_state);
    saw_ascii_next  = saw_ascii | ~is_high;
    saw_high_next   = saw_high | is_high;
    // a pair led by the final byte is never tested, since the line state clears, so it never matches
    first_pair_hit_next = first_pair_hit;
    if (prior_was_high && first_pair_hit == HIT_NONE) begin
      if (pair_gbk(prior_byte, beat.data)) first_pair_hit_next = HIT_GBK;
      else if (pair_big5(prior_byte, beat.data)) first_pair_hit_next = HIT_BIG5;
    end
  end

  always_comb begin
    if (saw_high_next && dfa_state_next == U8_START) code = CODE_UTF8;
    else if (first_pair_hit_next == HIT_GBK) code = CODE_GBK;
    else if (first_pair_hit_next == HIT_BIG5) code = CODE_BIG5;
    else if (saw_ascii_next) code = CODE_ASCII;
    else code = CODE_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && beat.last)) begin
      dfa_state      <= U8_START;
      prior_byte     <= 8'h00;
      prior_was_high <= 1'b0;
      first_pair_hit <= HIT_NONE;
      saw_ascii      <= 1'b0;
      saw_high       <= 1'b0;
    end else if (advance) begin
      dfa_state      <= dfa_state_next;
      prior_byte     <= beat.data;
      prior_was_high <= is_high;
      first_pair_hit <= first_pair_hit_next;
      saw_ascii      <= saw_ascii_next;
      saw_high       <= saw_high_next;
    end
  end

endmodule

@@ sv/text_encoding_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector: classify one line as ASCII, UTF-8, GBK or Big5
// Input register, per-beat detection logic, result register.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall with data_byte and last_byte. Send the
//   bytes of one line in order, one per beat, with last_byte set on the final
//   one. Lines follow each other with no gap.
//   Output channel: out_valid / out_stall with code_type. One beat per line:
//   0 unknown, 1 ascii, 2 utf8, 3 gbk, 4 big5. Non-final bytes give nothing.
//   Path: a final byte accepted into the input register moves on to the result
//   register once that register is free, and its code then shows at out_valid.
//   Throughput: one byte per cycle while no final byte waits on a held code;
//   the UTF-8 automaton and pair compares sit between the two registers.
//   Stall: while the result register holds an untaken code, a final byte
//   waits in the input register; other bytes keep flowing. in_stall rises
//   only when the input register is full and cannot advance.
//   Reset: synchronous, active high; clears both registers' valid flags and
//   all per-line state, so the next byte starts a new line.
// ----------------------------------------------------------------------------
module text_encoding_detector (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output ted_pkg::code_t code_type
);
  import ted_pkg::*;

  logic  q_valid;
  beat_t q_beat;
  logic  out_free;
  logic  advance;
  code_t line_code;

  // the result slot is free when empty or being taken this cycle
  assign out_free = ~out_valid | ~out_stall;
  // advance the held beat; a final beat needs room for its code
  assign advance  = q_valid & (~q_beat.last | out_free);
  assign in_stall = q_valid & ~advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (~in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (~in_stall && in_valid) begin
      q_beat.data <= data_byte;
      q_beat.last <= last_byte;
    end
  end

  ted_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .beat    (q_beat),
    .code    (line_code)
  );

  // result register: load on a final beat, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && q_beat.last) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_beat.last) begin
      code_type <= line_code;
    end
  end

  // a final beat that advances always lands a code
  a_final_lands: assert property (@(posedge clk) disable iff (rst)
    advance && q_beat.last |=> out_valid)
    else $error("final beat advanced without a result");

  // a taken code with nothing behind it empties the result slot
  a_drop_taken: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !(advance && q_beat.last) |=> !out_valid)
    else $error("result repeated after it was taken");

  // a shown code is one of the defined encodings
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (code_type == CODE_UNKNOWN || code_type == CODE_ASCII ||
                   code_type == CODE_UTF8 || code_type == CODE_GBK ||
                   code_type == CODE_BIG5))
    else $error("code out of range");

  // back-pressure only from a full input register holding a blocked final beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && q_beat.last && out_valid && out_stall)
    else $error("input stalled without cause");

endmodule

@@ verif/text_encoding_detector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector_tb: self-checking bench for the line encoding detector
// Drives lines of bytes over the valid/stall input channel, runs a behavioral
// classifier on every accepted beat and checks each code_type beat in order.
// A short scripted part covers the edges; random lines follow.
// ----------------------------------------------------------------------------
module text_encoding_detector_tb;
  import ted_pkg::*;

  localparam int NUM_SCRIPT  = 25;
  localparam int RAND_BYTES  = 2000;
  localparam int IDLE_PCT    = 36;
  localparam int REPORT_MAX  = 10;
  localparam int DRAIN_LIMIT = 5000;

  // one scripted beat; pinned rows carry a code read straight off the spec
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       pinned;
    code_t      code;
  } stim_row_t;

  // Walk order matters: each final beat closes the line built by the rows
  // above it.
  localparam stim_row_t SCRIPT [0:NUM_SCRIPT-1] = '{
    // single-byte lines at the byte extremes: the code is obvious
    '{8'h00, 1'b1, 1'b1, CODE_ASCII},
    '{8'hFF, 1'b1, 1'b1, CODE_UNKNOWN},
    '{8'h7F, 1'b1, 1'b1, CODE_ASCII},
    '{8'h80, 1'b1, 1'b1, CODE_UNKNOWN},
    // two-byte UTF-8 character
    '{8'hC3, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hA9, 1'b1, 1'b0, CODE_UNKNOWN},
    // GBK pair whose lead is a stray continuation for UTF-8
    '{8'hB0, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hA1, 1'b1, 1'b0, CODE_UNKNOWN},
    // pair with a low trail byte, also inside the Big5 ranges
    '{8'hA1, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'h40, 1'b1, 1'b0, CODE_UNKNOWN},
    // line ends on a high byte: its follower counts as zero
    '{8'h41, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'h81, 1'b1, 1'b0, CODE_UNKNOWN},
    // three-byte character
    '{8'hE4, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hB8, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hAD, 1'b1, 1'b0, CODE_UNKNOWN},
    // four-byte character through the F0 lead
    '{8'hF0, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'h9F, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'h98, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'h80, 1'b1, 1'b0, CODE_UNKNOWN},
    // trail 0xFF falls outside every pair range
    '{8'h81, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hFF, 1'b1, 1'b0, CODE_UNKNOWN},
    // surrogate lead: UTF-8 fails, the pair still matches GBK
    '{8'hED, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hA0, 1'b1, 1'b0, CODE_UNKNOWN},
    // top of both ranges
    '{8'hFE, 1'b0, 1'b0, CODE_UNKNOWN},
    '{8'hFE, 1'b1, 1'b0, CODE_UNKNOWN}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_stall;
  code_t      code_type;

  // side-band that travels with each beat: a pinned code overrides the
  // classifier for that line
  logic       pin_on;
  code_t      pin_code;
  logic       quiet;        // high while neither side idles

  // classifier state, one line deep
  u8_state_t  dfa;
  logic [7:0] prev_byte;
  logic       prev_high;
  hit_t       pair_hit;
  logic       any_ascii;
  logic       any_high;

  code_t      expected_codes [$];
  logic [7:0] line_q [$];
  int         errors;
  int         bytes_sent;

  text_encoding_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_type (code_type)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("text_encoding_detector_tb: done, errors");
    $finish;
  end

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("ERROR: %s", msg);
  endfunction

  // ---------------------------------------------------------------- classifier

  function automatic void clear_line();
    dfa       = U8_START;
    prev_byte = 8'h00;
    prev_high = 1'b0;
    pair_hit  = HIT_NONE;
    any_ascii = 1'b0;
    any_high  = 1'b0;
  endfunction

  // Step the UTF-8 validator; anything off the legal paths lands in the
  // error state, which never leaves.
  function automatic u8_state_t utf8_advance(input u8_state_t st, input logic [7:0] b);
    u8_state_t nx;
    nx = U8_ERR;
    if (st == U8_START) begin
      if (!b[7]) nx = U8_START;
      else if (b >= 8'hC2 && b <= 8'hDF) nx = U8_A;
      else if (b == 8'hE0) nx = U8_C;
      else if (b == 8'hED) nx = U8_D;
      else if (b >= 8'hE1 && b <= 8'hEF) nx = U8_B;
      else if (b == 8'hF0) nx = U8_F;
      else if (b >= 8'hF1 && b <= 8'hF3) nx = U8_E;
      else if (b == 8'hF4) nx = U8_G;
    end else if (b >= 8'h80 && b <= 8'hBF) begin
      // continuation: some leads narrow the window of the first one
      case (st)
        U8_A:    nx = U8_START;
        U8_B:    nx = U8_A;
        U8_C:    if (b >= 8'hA0) nx = U8_A;
        U8_D:    if (b < 8'hA0) nx = U8_A;
        U8_E:    nx = U8_B;
        U8_F:    if (b >= 8'h90) nx = U8_B;
        U8_G:    if (b < 8'h90) nx = U8_B;
        default: nx = U8_ERR;
      endcase
    end
    return nx;
  endfunction

  function automatic bit gbk_pair(input logic [7:0] hi, input logic [7:0] lo);
    return hi >= 8'h81 && hi != 8'hFF &&
           ((lo >= 8'h40 && lo <= 8'h7E) || (lo[7] && lo != 8'hFF));
  endfunction

  function automatic bit big5_pair(input logic [7:0] hi, input logic [7:0] lo);
    return hi >= 8'hA1 && hi != 8'hFF &&
           ((lo >= 8'h40 && lo <= 8'h7E) || (lo >= 8'hA1 && lo != 8'hFF));
  endfunction

  // keep only the first pair of the line that matches
  function automatic void note_pair(input logic [7:0] hi, input logic [7:0] lo);
    if (pair_hit != HIT_NONE) return;
    if (gbk_pair(hi, lo)) pair_hit = HIT_GBK;
    else if (big5_pair(hi, lo)) pair_hit = HIT_BIG5;
  endfunction

  // Take one accepted byte; return 1 with the line's code on the final byte.
  function automatic bit classify_byte(input logic [7:0] b, input logic fin,
                                       output code_t code);
    code = CODE_UNKNOWN;
    if (prev_high) note_pair(prev_byte, b);
    dfa = utf8_advance(dfa, b);
    if (b[7]) any_high = 1'b1;
    else any_ascii = 1'b1;
    if (!fin) begin
      prev_byte = b;
      prev_high = b[7];
      return 1'b0;
    end
    // nothing follows the final byte; pair it with zero
    if (b[7]) note_pair(b, 8'h00);
    if (any_high && dfa == U8_START) code = CODE_UTF8;
    else if (pair_hit == HIT_GBK) code = CODE_GBK;
    else if (pair_hit == HIT_BIG5) code = CODE_BIG5;
    else if (any_ascii) code = CODE_ASCII;
    clear_line();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  // Sample both channels at the edge; every signal here changes only through
  // nonblocking updates, so these are the pre-edge values.
  always @(posedge clk) begin
    code_t want;
    bit    closed;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        closed = classify_byte(data_byte, last_byte, want);
        if (closed) begin
          if (pin_on) want = pin_code;
          expected_codes.push_back(want);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          flag_error($sformatf("code_type beat %0d with no line closed", code_type));
        end else begin
          want = expected_codes.pop_front();
          if (code_type !== want)
            flag_error($sformatf("code_type expected %0d, got %0d", want, code_type));
        end
      end
    end
  end

  // Receiver back-pressure, off during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------- stimulus

  // Present one beat and hold it until taken; idle first at random.
  task automatic send_beat(input logic [7:0] d, input logic fin, input logic pin,
                           input code_t pcode);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= fin;
    pin_on    <= pin;
    pin_code  <= pcode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int unsigned pick_codepoint();
    int unsigned cp;
    case ($urandom_range(0, 3))
      0: cp = $urandom_range(0, 32'h7F);
      1: cp = $urandom_range(32'h80, 32'h7FF);
      2: begin
        cp = $urandom_range(32'h800, 32'hFFFF);
        // skip the surrogate block
        if (cp >= 32'hD800 && cp <= 32'hDFFF) cp = cp - 32'h800;
      end
      default: cp = $urandom_range(32'h10000, 32'h10FFFF);
    endcase
    return cp;
  endfunction

  function automatic void put_codepoint(input int unsigned cp);
    if (cp < 32'h80) begin
      line_q.push_back(8'(cp));
    end else if (cp < 32'h800) begin
      line_q.push_back(8'(32'hC0 | (cp >> 6)));
      line_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else if (cp < 32'h10000) begin
      line_q.push_back(8'(32'hE0 | (cp >> 12)));
      line_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      line_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end else begin
      line_q.push_back(8'(32'hF0 | (cp >> 18)));
      line_q.push_back(8'(32'h80 | ((cp >> 12) & 32'h3F)));
      line_q.push_back(8'(32'h80 | ((cp >> 6) & 32'h3F)));
      line_q.push_back(8'(32'h80 | (cp & 32'h3F)));
    end
  endfunction

  // Build one random line: mostly well-formed text of each flavor, some raw
  // noise and some UTF-8 that gets broken on purpose.
  function automatic void build_line();
    int kind;
    int n;
    line_q.delete();
    kind = $urandom_range(0, 9);
    n    = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      case (kind)
        0, 1, 2, 3, 8: put_codepoint(pick_codepoint());
        4, 5: begin
          if ($urandom_range(0, 3) == 0) begin
            line_q.push_back(8'($urandom_range(0, 8'h7F)));
          end else begin
            line_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
            if ($urandom_range(0, 1) == 0) line_q.push_back(8'($urandom_range(8'h40, 8'h7E)));
            else line_q.push_back(8'($urandom_range(8'h80, 8'hFE)));
          end
        end
        6: begin
          line_q.push_back(8'($urandom_range(8'hA1, 8'hFE)));
          if ($urandom_range(0, 1) == 0) line_q.push_back(8'($urandom_range(8'h40, 8'h7E)));
          else line_q.push_back(8'($urandom_range(8'hA1, 8'hFE)));
        end
        7: line_q.push_back(8'($urandom_range(0, 255)));
        default: line_q.push_back(8'($urandom_range(0, 8'h7F)));
      endcase
    end
    if (kind == 8) begin
      case ($urandom_range(0, 2))
        0: if (line_q.size() > 1) void'(line_q.pop_back());
        1: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        default: line_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      endcase
    end
  endfunction

  initial begin
    int waited;
    clear_line();
    errors     = 0;
    bytes_sent = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    pin_on    <= 1'b0;
    pin_code  <= CODE_UNKNOWN;
    quiet     <= 1'b0;
    out_stall <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // scripted edges first
    for (int r = 0; r < NUM_SCRIPT; r++)
      send_beat(SCRIPT[r].data, SCRIPT[r].fin, SCRIPT[r].pinned, SCRIPT[r].code);

    // random lines; hold both sides busy for one stretch in the middle
    while (bytes_sent < RAND_BYTES) begin
      quiet <= (bytes_sent >= 800 && bytes_sent < 1200);
      build_line();
      for (int k = 0; k < line_q.size(); k++)
        send_beat(line_q[k], k == line_q.size() - 1, 1'b0, CODE_UNKNOWN);
      bytes_sent += line_q.size();
    end
    in_valid <= 1'b0;

    // drain: two register stages plus receiver stalls, bounded
    waited = 0;
    @(posedge clk);
    while (expected_codes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_codes.size() != 0)
      flag_error($sformatf("%0d code_type beat(s) never arrived, next expected %0d",
                           expected_codes.size(), expected_codes[0]));

    if (errors == 0) begin
      $display("text_encoding_detector_tb: done, clean");
    end else begin
      $display("text_encoding_detector_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ted_pkg.sv
sv/ted_core.sv
sv/text_encoding_detector.sv
verif/text_encoding_detector_tb.sv
